// ----- src/lspb_pkg.sv -----
// Shared types, register codes and the log edge table generator for the spectrum bar block.
// No dependencies.
package lspb_pkg;

	localparam int BAR_COUNT_DEF = 32;
	localparam int MAX_BINS_DEF  = 1024;
	localparam int MAG_WIDTH_DEF = 16;

	// edge ratio width: 2^10 in Q.16 needs 27 bits
	localparam int RW = 27;

	localparam logic [1:0] REG_BINS   = 2'd0;
	localparam logic [1:0] REG_GAIN   = 2'd1;
	localparam logic [1:0] REG_HDECAY = 2'd2;
	localparam logic [1:0] REG_PDECAY = 2'd3;

	localparam logic [10:0] BINS_RST   = 11'd1024;
	localparam logic [15:0] GAIN_RST   = 16'd19661;
	localparam logic [15:0] HDECAY_RST = 16'd62259;
	localparam logic [15:0] PDECAY_RST = 16'd64881;

	typedef struct packed {
		logic wr_bin;
		logic clr_wp;
		logic start_pass;
		logic edge_s;
		logic edge_e;
		logic edge_fix;
		logic sum_run;
		logic div_start;
		logic div_run;
		logic m1;
		logic m2;
		logic m3;
		logic m4;
		logic m5;
		logic next_bar;
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic div_done;
		logic last_k;
	} stat_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = xin;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int t = 0; t < 32; t++) begin
			if (b > x) b = b >> 2;
		end
		for (int t = 0; t < 32; t++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(10j/nbars) in Q.16
	function automatic logic [RW-1:0] edge_rom(input int j, input int nbars);
		logic [63:0] p;
		logic [63:0] ip;
		logic [63:0] fr;
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] res;
		p  = 64'(10 * j);
		ip = p / 64'(nbars);
		fr = ((p % 64'(nbars)) << 16) / 64'(nbars);
		m  = 64'd1 << 30;
		r  = 64'd2 << 30;
		for (int b = 1; b <= 16; b++) begin
			r = isqrt64(r << 30);
			if (fr[16-b]) m = (m * r) >> 30;
		end
		res = (m << ip) >> 14;
		return res[RW-1:0];
	endfunction

endpackage

// ----- src/lspb_ctrl.sv -----
// Sequencer for bin loading and the per-bar pass.
// Depends on lspb_pkg.
module lspb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_bin,
	input  logic              out_stall,
	input  lspb_pkg::stat_t   st,
	output lspb_pkg::cmd_t    cmd,
	output logic              in_stall,
	output logic              out_valid
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ES   = 4'd1;
	localparam logic [3:0] S_EE   = 4'd2;
	localparam logic [3:0] S_EF   = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_DVS  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_M3   = 4'd9;
	localparam logic [3:0] S_M4   = 4'd10;
	localparam logic [3:0] S_M5   = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_n;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.wr_bin = 1'b1;
					if (last_bin) begin
						cmd.clr_wp     = 1'b1;
						cmd.start_pass = 1'b1;
						state_n        = S_ES;
					end
				end
			end
			S_ES: begin
				cmd.edge_s = 1'b1;
				state_n    = S_EE;
			end
			S_EE: begin
				cmd.edge_e = 1'b1;
				state_n    = S_EF;
			end
			S_EF: begin
				cmd.edge_fix = 1'b1;
				state_n      = S_SUM;
			end
			S_SUM: begin
				if (st.sum_done) state_n = S_DVS;
				else cmd.sum_run = 1'b1;
			end
			S_DVS: begin
				cmd.div_start = 1'b1;
				state_n       = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) state_n = S_M1;
				else cmd.div_run = 1'b1;
			end
			S_M1: begin
				cmd.m1  = 1'b1;
				state_n = S_M2;
			end
			S_M2: begin
				cmd.m2  = 1'b1;
				state_n = S_M3;
			end
			S_M3: begin
				cmd.m3  = 1'b1;
				state_n = S_M4;
			end
			S_M4: begin
				cmd.m4  = 1'b1;
				state_n = S_M5;
			end
			S_M5: begin
				cmd.m5  = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					if (st.last_k) begin
						state_n = S_IDLE;
					end else begin
						cmd.next_bar = 1'b1;
						state_n      = S_ES;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

endmodule

// ----- src/lspb_dp.sv -----
// Datapath: bin memory, edge table, accumulator, divider, smoothing and peak arithmetic.
// Depends on lspb_pkg.
module lspb_dp #(
	parameter int BAR_COUNT = lspb_pkg::BAR_COUNT_DEF,
	parameter int MAX_BINS  = lspb_pkg::MAX_BINS_DEF,
	parameter int MAG_WIDTH = lspb_pkg::MAG_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lspb_pkg::cmd_t   cmd,
	output lspb_pkg::stat_t  st,
	input  logic [15:0]      magnitude,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output logic [4:0]       bar_index,
	output logic [15:0]      bar_height,
	output logic [15:0]      bar_peak,
	output logic             last_bar
);

	localparam int AW    = $clog2(MAX_BINS);
	localparam int NB_W  = AW + 1;
	localparam int KW    = $clog2(BAR_COUNT);
	localparam int RW    = lspb_pkg::RW;
	localparam int SUM_W = MAG_WIDTH + AW;
	localparam int CW    = $clog2(SUM_W + 1);

	logic [10:0] bins_q;
	logic [15:0] gain_q;
	logic [15:0] hdec_q;
	logic [15:0] pdec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= lspb_pkg::BINS_RST;
			gain_q <= lspb_pkg::GAIN_RST;
			hdec_q <= lspb_pkg::HDECAY_RST;
			pdec_q <= lspb_pkg::PDECAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lspb_pkg::REG_BINS:   bins_q <= cfg_data[10:0];
				lspb_pkg::REG_GAIN:   gain_q <= cfg_data;
				lspb_pkg::REG_HDECAY: hdec_q <= cfg_data;
				lspb_pkg::REG_PDECAY: pdec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NB_W-1:0] nb;
	always_comb begin
		if (bins_q < 11'd2) nb = NB_W'(2);
		else if (int'(bins_q) > MAX_BINS) nb = NB_W'(MAX_BINS);
		else nb = NB_W'(bins_q);
	end

	// bin memory
	logic [MAG_WIDTH-1:0] mem [MAX_BINS];
	logic [NB_W-1:0]      wp_q;
	logic [NB_W-1:0]      addr_q;
	logic [MAG_WIDTH-1:0] rd_q;
	logic                 rdv_q;
	logic                 mem_we;
	logic                 rd_en;

	assign mem_we = cmd.wr_bin && (int'(wp_q) < MAX_BINS);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q[AW-1:0]] <= MAG_WIDTH'(magnitude);
		if (rd_en) rd_q <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wp_q <= '0;
		else if (cmd.clr_wp) wp_q <= '0;
		else if (mem_we) wp_q <= wp_q + 1'b1;
	end

	// edge table
	logic [RW-1:0] rom [BAR_COUNT+1];
	for (genvar g = 0; g <= BAR_COUNT; g++) begin : g_rom
		localparam logic [RW-1:0] V = lspb_pkg::edge_rom(g, BAR_COUNT);
		assign rom[g] = V;
	end

	logic [KW:0]          k_q;
	logic [RW+NB_W-1:0]   prod_q;
	logic [NB_W-1:0]      s_q;
	logic [NB_W-1:0]      e_q;
	logic [NB_W-1:0]      edge_c;
	logic [NB_W-1:0]      edge_raw;

	assign edge_raw = prod_q[26 +: NB_W];
	assign edge_c   = (edge_raw >= nb) ? (nb - 1'b1) : edge_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= '0;
		else if (cmd.start_pass) k_q <= '0;
		else if (cmd.next_bar) k_q <= k_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_s) prod_q <= rom[k_q] * nb;
		if (cmd.edge_e) begin
			s_q    <= edge_c;
			prod_q <= rom[k_q + 1'b1] * nb;
		end
		if (cmd.edge_fix) e_q <= (edge_c <= s_q) ? (s_q + 1'b1) : edge_c;
	end

	// accumulate bins [s, e)
	logic [SUM_W-1:0] sum_q;
	assign rd_en = cmd.sum_run && (addr_q != e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rdv_q <= 1'b0;
		else rdv_q <= rd_en;
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_fix) begin
			addr_q <= s_q;
			sum_q  <= '0;
		end else if (cmd.sum_run) begin
			if (rd_en) addr_q <= addr_q + 1'b1;
			if (rdv_q) sum_q <= sum_q + SUM_W'(rd_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [NB_W-1:0]  dvs_q;
	logic [NB_W-1:0]  rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic [NB_W:0]    rem_n;

	assign rem_n = {rem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvs_q <= e_q - s_q;
			rem_q <= '0;
			quo_q <= sum_q;
			cnt_q <= CW'(SUM_W);
		end else if (cmd.div_run) begin
			cnt_q <= cnt_q - 1'b1;
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_q <= NB_W'(rem_n - {1'b0, dvs_q});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_n[NB_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	// height and peak
	logic [MAG_WIDTH-1:0] hgt_q [BAR_COUNT];
	logic [MAG_WIDTH-1:0] pk_q  [BAR_COUNT];
	logic [MAG_WIDTH-1:0] old_q;
	logic [MAG_WIDTH-1:0] pold_q;
	logic [MAG_WIDTH+15:0] pa_q;
	logic [MAG_WIDTH+16:0] pb_q;
	logic [MAG_WIDTH+15:0] pc_q;
	logic [MAG_WIDTH-1:0] blend_q;
	logic [MAG_WIDTH-1:0] h_q;
	logic [MAG_WIDTH-1:0] dec;
	logic [MAG_WIDTH+17:0] bsum;
	logic [MAG_WIDTH+15:0] pdp;
	logic [MAG_WIDTH-1:0] pnew;
	logic [KW-1:0]        ki;

	assign ki   = k_q[KW-1:0];
	assign dec  = pc_q[16 +: MAG_WIDTH];
	assign bsum = (MAG_WIDTH+18)'(pa_q) + (MAG_WIDTH+18)'(pb_q);
	assign pdp  = pold_q * pdec_q;
	assign pnew = (h_q > pold_q) ? h_q : pdp[16 +: MAG_WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.m1) begin
			pa_q   <= gain_q * quo_q[MAG_WIDTH-1:0];
			old_q  <= hgt_q[ki];
			pold_q <= pk_q[ki];
		end
		if (cmd.m2) pb_q <= (17'h10000 - 17'(gain_q)) * old_q;
		if (cmd.m3) begin
			blend_q <= bsum[16 +: MAG_WIDTH];
			pc_q    <= old_q * hdec_q;
		end
		if (cmd.m4) h_q <= (blend_q > dec) ? blend_q : dec;
		if (cmd.m5) begin
			bar_index  <= 5'(k_q);
			bar_height <= 16'(h_q);
			bar_peak   <= 16'(pnew);
			last_bar   <= (k_q == (KW+1)'(BAR_COUNT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAR_COUNT; i++) begin
				hgt_q[i] <= '0;
				pk_q[i]  <= '0;
			end
		end else if (cmd.m5) begin
			hgt_q[ki] <= h_q;
			pk_q[ki]  <= pnew;
		end
	end

	assign st.sum_done = (addr_q == e_q) && !rdv_q;
	assign st.div_done = (cnt_q == '0);
	assign st.last_k   = (k_q == (KW+1)'(BAR_COUNT - 1));

endmodule

// ----- src/log_spectrum_bars_peak_hold.sv -----
// Bins load one per cycle while idle. The input carrying last_bin starts a pass over
// BAR_COUNT bars; the block stalls its input until the last bar result is transferred.
// Per bar: edge states ES, EE and EF, reads of bins s to e - 1, a bit-serial divide
// and the arithmetic states M1 to M5, then an output state that holds while out_stall
// is high. The bit-serial divider and the serial bin reads set the pass length.
module log_spectrum_bars_peak_hold #(
	parameter int BAR_COUNT = lspb_pkg::BAR_COUNT_DEF,
	parameter int MAX_BINS  = lspb_pkg::MAX_BINS_DEF,
	parameter int MAG_WIDTH = lspb_pkg::MAG_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] magnitude,
	input  logic        last_bin,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  bar_index,
	output logic [15:0] bar_height,
	output logic [15:0] bar_peak,
	output logic        last_bar,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lspb_pkg::cmd_t  cmd;
	lspb_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	lspb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_bin  (last_bin),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	lspb_dp #(
		.BAR_COUNT (BAR_COUNT),
		.MAX_BINS  (MAX_BINS),
		.MAG_WIDTH (MAG_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.magnitude  (magnitude),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.bar_index  (bar_index),
		.bar_height (bar_height),
		.bar_peak   (bar_peak),
		.last_bar   (last_bar)
	);

	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during result");

	a_last_bar_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_bar) |-> (bar_index == 5'(BAR_COUNT - 1)))
		else $error("last_bar on wrong bar");

	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_bin) |=> in_stall)
		else $error("pass did not start");

	a_gap_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result repeated");

endmodule

// ----- test/tb_log_spectrum_bars_peak_hold.sv -----
// Testbench for the log spectrum bar block with peak hold: frames of bins are driven in,
// bar results are predicted in the bench and checked in order. Depends on lspb_pkg.
`timescale 1ns / 100ps

module tb_log_spectrum_bars_peak_hold;

	localparam int NBARS = 32;
	localparam int NBINS = 1024;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		logic [15:0] mag;
		logic        last;
	} bin_t;

	typedef struct packed {
		logic [4:0]  idx;
		logic [15:0] height;
		logic [15:0] peak;
		logic        last;
	} bar_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] magnitude = '0;
	logic last_bin = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] bar_index;
	logic [15:0] bar_height;
	logic [15:0] bar_peak;
	logic last_bar;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	log_spectrum_bars_peak_hold u_top (.*);

	always #5 clk = ~clk;

	bin_t pending_bins[$];
	bar_t expected_bars[$];
	int errors = 0;
	int bars_seen = 0;
	int frames_done = 0;
	int idle_cycles = 0;
	int accepted_cnt = 0;
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;
	int hold_len = 0;

	// predictor state
	logic [15:0] bins_m[NBINS];
	int wpos = 0;
	logic [15:0] heights_m[NBARS];
	logic [15:0] peaks_m[NBARS];
	logic [10:0] cur_bins = lspb_pkg::BINS_RST;
	logic [15:0] cur_gain = lspb_pkg::GAIN_RST;
	logic [15:0] cur_hdec = lspb_pkg::HDECAY_RST;
	logic [15:0] cur_pdec = lspb_pkg::PDECAY_RST;
	logic [63:0] ratio[NBARS+1];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] x, r, b;
		x = v;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] pow_ratio(input int j);
		logic [63:0] p, ip, fr, m, r;
		p = 64'(10 * j);
		ip = p / NBARS;
		fr = ((p % NBARS) << 16) / NBARS;
		m = 64'd1 << 30;
		r = 64'd2 << 30;
		for (int b = 1; b <= 16; b++) begin
			r = int_sqrt(r << 30);
			if (fr[16-b]) m = (m * r) >> 30;
		end
		return (m << ip) >> 14;
	endfunction

	task automatic predict_bin(input bin_t it);
		logic [63:0] nb, s, e, sum, avg, old, blend, dec, h;
		bar_t res;
		if (wpos < NBINS) begin
			bins_m[wpos] = it.mag;
			wpos++;
		end
		if (it.last) begin
			wpos = 0;
			nb = 64'(cur_bins);
			if (nb < 2) nb = 2;
			if (nb > NBINS) nb = NBINS;
			for (int k = 0; k < NBARS; k++) begin
				s = (ratio[k] * nb) >> 26;
				e = (ratio[k+1] * nb) >> 26;
				if (s >= nb) s = nb - 1;
				if (e >= nb) e = nb - 1;
				if (e <= s) e = s + 1;
				sum = 0;
				for (logic [63:0] i = s; i < e; i++) sum += bins_m[i];
				avg = sum / (e - s);
				old = heights_m[k];
				blend = (cur_gain * avg + (65536 - cur_gain) * old) >> 16;
				dec = (old * cur_hdec) >> 16;
				h = blend > dec ? blend : dec;
				heights_m[k] = h[15:0];
				if (h > peaks_m[k]) peaks_m[k] = h[15:0];
				else peaks_m[k] = (64'(peaks_m[k]) * cur_pdec) >> 16;
				res.idx = k[4:0];
				res.height = h[15:0];
				res.peak = peaks_m[k];
				res.last = (k == NBARS - 1);
				expected_bars.push_back(res);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR bar %0d: %s got %0d expected %0d", bars_seen, what, got, want);
		errors++;
	endtask

	// driver
	int tx_gap = 0;
	int seen_cnt = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_cnt != seen_cnt) begin
				seen_cnt = accepted_cnt;
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_bins.size() > 0 && (quiet || $urandom_range(0, 7) != 0)) begin
					in_valid <= 1'b1;
					magnitude <= pending_bins[0].mag;
					last_bin <= pending_bins[0].last;
				end else begin
					in_valid <= 1'b0;
					if (!quiet && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 12);
				end
			end
		end
	end

	// transfer accounting at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_bin(pending_bins.pop_front());
			accepted_cnt++;
		end
	end

	// receiver stall
	int rx_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_rx) begin
				out_stall <= 1'b1;
				if (hold_len > 0) hold_len--;
				else hold_rx = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 12);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bar_t exp_bar;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bars.size() == 0) begin
				report_mismatch("unexpected result index", bar_index, 0);
			end else begin
				exp_bar = expected_bars.pop_front();
				if (bar_index !== exp_bar.idx) report_mismatch("index", bar_index, exp_bar.idx);
				if (bar_height !== exp_bar.height)
					report_mismatch("height", bar_height, exp_bar.height);
				if (bar_peak !== exp_bar.peak) report_mismatch("peak", bar_peak, exp_bar.peak);
				if (last_bar !== exp_bar.last) report_mismatch("last", last_bar, exp_bar.last);
				if (exp_bar.last) frames_done++;
			end
			bars_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| hold_rx || pending_bins.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lspb_pkg::REG_BINS:   cur_bins = val[10:0];
			lspb_pkg::REG_GAIN:   cur_gain = val;
			lspb_pkg::REG_HDECAY: cur_hdec = val;
			lspb_pkg::REG_PDECAY: cur_pdec = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		while ((pending_bins.size() > 0 || expected_bars.size() > 0) && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 2000000) begin
			$display("Test completed with failures");
			$finish;
		end
		repeat (20) @(posedge clk);
	endtask

	// queue one frame of n bins; a zero count frame is never produced
	task automatic push_frame(input int n, input int mode);
		bin_t b;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: b.mag = 16'($urandom);
				1: b.mag = 16'hFFFF;
				2: b.mag = 16'h0000;
				default: b.mag = ($urandom_range(0, 1) ? 16'(1 << $urandom_range(0, 15))
					: 16'($urandom));
			endcase
			b.last = (i == n - 1);
			pending_bins.push_back(b);
		end
	endtask

	int nb;
	int flen;
	int items_sent = 0;
	initial begin
		for (int j = 0; j <= NBARS; j++) ratio[j] = pow_ratio(j);
		for (int k = 0; k < NBARS; k++) begin
			heights_m[k] = 0;
			peaks_m[k] = 0;
		end
		foreach (bins_m[i]) bins_m[i] = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: smallest frames, extreme gains and decays
		write_reg(lspb_pkg::REG_BINS, 16'd2);
		push_frame(2, 1);
		drain();
		push_frame(2, 2);
		drain();
		write_reg(lspb_pkg::REG_GAIN, 16'hFFFF);
		write_reg(lspb_pkg::REG_HDECAY, 16'h0000);
		write_reg(lspb_pkg::REG_PDECAY, 16'hFFFF);
		push_frame(2, 1);
		drain();
		write_reg(lspb_pkg::REG_GAIN, 16'h0000);
		write_reg(lspb_pkg::REG_PDECAY, 16'h0000);
		write_reg(lspb_pkg::REG_HDECAY, 16'hFFFF);
		push_frame(3, 0);
		drain();
		// bin count below range acts as two, then a short frame keeps old bins
		write_reg(lspb_pkg::REG_BINS, 16'd0);
		write_reg(lspb_pkg::REG_GAIN, 16'd40000);
		push_frame(2, 3);
		drain();
		write_reg(lspb_pkg::REG_BINS, 16'd16);
		push_frame(16, 0);
		push_frame(4, 1);
		drain();
		items_sent = 31;

		// a larger frame, a short one behind it and a long receiver hold
		write_reg(lspb_pkg::REG_BINS, 16'd48);
		write_reg(lspb_pkg::REG_HDECAY, lspb_pkg::HDECAY_RST);
		write_reg(lspb_pkg::REG_PDECAY, lspb_pkg::PDECAY_RST);
		push_frame(48, 0);
		push_frame(5, 0);
		hold_len = 300;
		hold_rx = 1'b1;
		drain();
		items_sent += 53;

		// random part: short frames with random settings
		while (items_sent < 360) begin
			if ($urandom_range(0, 2) == 0) begin
				write_reg(lspb_pkg::REG_BINS, 16'($urandom_range(2, 48)));
				write_reg(lspb_pkg::REG_GAIN, 16'($urandom));
				write_reg(lspb_pkg::REG_HDECAY, 16'($urandom));
				write_reg(lspb_pkg::REG_PDECAY, 16'($urandom));
			end
			nb = (cur_bins < 2) ? 2 : int'(cur_bins);
			flen = ($urandom_range(1, 4) == 1) ? int'($urandom_range(1, nb)) : nb;
			push_frame(flen, $urandom_range(0, 3));
			items_sent += flen;
			if (items_sent > 300) quiet = 1'b1;
			drain();
		end
		quiet = 1'b1;
		drain();

		$display("Covered %0d frames and %0d bar results over several register settings,",
			frames_done, bars_seen);
		$display("including clamped bin counts, short frames and a long receiver hold.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/lspb_pkg.sv
src/lspb_ctrl.sv
src/lspb_dp.sv
src/log_spectrum_bars_peak_hold.sv
test/tb_log_spectrum_bars_peak_hold.sv
